// ----- hw/rtl/sact_pkg.sv -----
// shared types, constants and helper function of the cache tag lookup unit
`timescale 1ns / 1ps
`default_nettype none

package sact_pkg;

    localparam int DEF_MAX_SETS  = 512;
    localparam int DEF_MAX_WAYS  = 16;
    localparam int DEF_ADDR_BITS = 32;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 4;
    localparam int SET_OUT_W  = 9;
    localparam int MODE_W     = 2;
    localparam int OFFS_W     = 5;
    localparam int SBITS_W    = 4;
    localparam int WAYS_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int LFSR_W     = 16;
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYCLES = LFSR_W / MOD_STEP;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIFO       = 2'd0,
        MODE_LRU        = 2'd1,
        MODE_RANDOM     = 2'd2,
        MODE_RANDOM_ALT = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPLACE_MODE      = 2'd0,
        CFG_BLOCK_OFFSET_BITS = 2'd1,
        CFG_SET_INDEX_BITS    = 2'd2,
        CFG_WAYS_IN_USE       = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_MOD,
        ST_WRITE
    } state_t;

    // taps 16,14,13,11, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sact_if.sv -----
// handshake channel interfaces of the cache tag lookup unit
`timescale 1ns / 1ps
`default_nettype none

interface sact_cfg_if import sact_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface sact_lookup_if import sact_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface sact_result_if import sact_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic [SET_OUT_W-1:0] set_used;
    logic [CNT_W-1:0]     access_total;
    logic [CNT_W-1:0]     hit_total;

    modport source (output valid, output hit, output way_used, output set_used,
                    output access_total, output hit_total, input ready);
    modport sink   (input valid, input hit, input way_used, input set_used,
                    input access_total, input hit_total, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/set_assoc_cache_tag_lookup_unit.sv -----
// set-associative cache tag lookup with fifo, lru and random replacement
// sequence: ST_IDLE takes an address and reads its set, ST_READ, ST_DECIDE, ST_MOD on a
//   random-mode miss (4-bit-per-cycle remainder unit for lfsr mod ways), ST_WRITE (waits
//   for the result slot), back to ST_IDLE; set state is one read then one write per access
// reset: async active low; then a clearing pass over all MAX_SETS sets writes the metadata
//   memory (valid bits, fifo pointers, lru order) before the first address is taken
// configuration writes are taken at any time, one per cycle
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_lookup_unit import sact_pkg::*; #(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sact_cfg_if.sink     cfg,
    sact_lookup_if.sink  lookup,
    sact_result_if.source result
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;   // floor log2 of set count
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int MCNT_W = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;
    localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

    // per-set metadata row
    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [WAY_W-1:0]               fifo_ptr;
        logic [MAX_WAYS-1:0][WAY_W-1:0] lru;      // index 0 is the oldest
    } meta_t;

    // configuration registers
    logic [MODE_W-1:0]  mode_reg;
    logic [OFFS_W-1:0]  offs_reg;
    logic [SBITS_W-1:0] sbits_reg;
    logic [WAYS_W-1:0]  ways_reg;

    // control
    state_t             state_reg, state_next;
    logic [SET_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [MCNT_W-1:0]  mod_cnt_reg, mod_cnt_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic [CNT_W-1:0]   acc_cnt_reg, acc_cnt_next;
    logic [CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // datapath
    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [MAX_WAYS-1:0] hit_vec_reg;
    logic                hit_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [WCNT_W-1:0]   rem_reg;
    logic [LFSR_W-1:0]   quo_reg;

    logic                 out_hit_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;
    logic [SET_OUT_W-1:0] out_set_reg;
    logic [CNT_W-1:0]     out_acc_reg;
    logic [CNT_W-1:0]     out_hits_reg;

    // memories
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
    meta_t                          meta_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd_reg;
    meta_t                          meta_rd_reg;

    logic                           mem_rd_en;
    logic                           tag_we;
    logic                           meta_we;
    logic [SET_W-1:0]               wr_addr;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_wr_data;
    meta_t                          meta_wr_data;
    meta_t                          meta_init;
    meta_t                          meta_upd;

    // address split
    logic [63:0]        addr_full;
    logic [SBITS_W-1:0] sbits_eff;
    logic [SET_W-1:0]   set_idx;
    logic [TAG_W-1:0]   tag_val;
    logic [WCNT_W-1:0]  ways_eff;

    logic                in_acc;
    logic                out_free;
    logic                rnd_mode;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    lru_victim;
    logic [WAY_W-1:0]    victim;
    logic [WCNT_W-1:0]   rem_step;
    logic [LFSR_W-1:0]   quo_step;
    logic [WAY_W-1:0]    lru_pos;

    assign lookup.ready = (state_reg == ST_IDLE);
    assign in_acc       = lookup.valid && lookup.ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_valid_reg || result.ready;
    assign rnd_mode     = (mode_reg != MODE_FIFO) && (mode_reg != MODE_LRU);

    assign result.valid        = out_valid_reg;
    assign result.hit          = out_hit_reg;
    assign result.way_used     = out_way_reg;
    assign result.set_used     = out_set_reg;
    assign result.access_total = out_acc_reg;
    assign result.hit_total    = out_hits_reg;

    // set bits clipped to the memory, associativity clipped to 1..MAX_WAYS
    always_comb
    begin
        addr_full = 64'(lookup.address) & ADDR_MASK;
        sbits_eff = (32'(sbits_reg) > 32'(SMAX)) ? SBITS_W'(SMAX) : sbits_reg;
        set_idx   = SET_W'((addr_full >> offs_reg) & ((64'd1 << sbits_eff) - 64'd1));
        tag_val   = TAG_W'(addr_full >> (6'(offs_reg) + 6'(sbits_eff)));
        if (ways_reg == '0)
            ways_eff = WCNT_W'(1);
        else if (6'(ways_reg) > 6'(MAX_WAYS))
            ways_eff = WCNT_W'(MAX_WAYS);
        else
            ways_eff = WCNT_W'(ways_reg);
    end

    // tag compare against the ways in use
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
            hit_vec[w] = meta_rd_reg.valid[w] && (tag_rd_reg[w] == tag_reg)
                         && (WCNT_W'(w) < ways_eff);
    end

    // highest matching way, oldest lru way in use, fifo victim
    always_comb
    begin
        logic found;
        found      = 1'b0;
        hit_way    = '0;
        lru_victim = '0;
        for (int w = 0; w < MAX_WAYS; w++)
            if (hit_vec_reg[w])
                hit_way = WAY_W'(w);
        for (int i = 0; i < MAX_WAYS; i++)
            if (!found && (WCNT_W'(meta_rd_reg.lru[i]) < ways_eff))
            begin
                lru_victim = meta_rd_reg.lru[i];
                found      = 1'b1;
            end
        if (mode_reg == MODE_FIFO)
            victim = (WCNT_W'(meta_rd_reg.fifo_ptr) < ways_eff) ? meta_rd_reg.fifo_ptr : '0;
        else
            victim = lru_victim;
    end

    // remainder unit, a few quotient bits per cycle
    always_comb
    begin
        logic [WCNT_W:0] part;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int b = 0; b < MOD_STEP; b++)
        begin
            part     = {rem_step, quo_step[LFSR_W-1]};
            quo_step = {quo_step[LFSR_W-2:0], 1'b0};
            if (part >= (WCNT_W + 1)'(ways_eff))
                part = part - (WCNT_W + 1)'(ways_eff);
            rem_step = WCNT_W'(part);
        end
    end

    // metadata update for the access in flight
    always_comb
    begin
        meta_upd = meta_rd_reg;
        lru_pos  = '0;
        if (!hit_reg)
            meta_upd.valid[way_reg] = 1'b1;
        if (!hit_reg && (mode_reg == MODE_FIFO))
            meta_upd.fifo_ptr = (WCNT_W'(WCNT_W'(way_reg) + WCNT_W'(1)) == ways_eff) ? '0
                                : WAY_W'(WCNT_W'(way_reg) + WCNT_W'(1));
        for (int i = 0; i < MAX_WAYS; i++)
            if (meta_rd_reg.lru[i] == way_reg)
                lru_pos = WAY_W'(i);
        if (mode_reg == MODE_LRU)
        begin
            // touched way moves to the most recent end
            for (int i = 0; i < MAX_WAYS - 1; i++)
                meta_upd.lru[i] = (WAY_W'(i) < lru_pos) ? meta_rd_reg.lru[i]
                                                        : meta_rd_reg.lru[i+1];
            meta_upd.lru[MAX_WAYS-1] = way_reg;
        end
    end

    always_comb
    begin
        meta_init.valid    = '0;
        meta_init.fifo_ptr = '0;
        for (int i = 0; i < MAX_WAYS; i++)
            meta_init.lru[i] = WAY_W'(i);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        mod_cnt_next   = mod_cnt_reg;
        lfsr_next      = lfsr_reg;
        acc_cnt_next   = acc_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        mem_rd_en      = 1'b0;
        tag_we         = 1'b0;
        meta_we        = 1'b0;
        wr_addr        = set_reg;
        meta_wr_data   = meta_upd;
        tag_wr_data    = tag_rd_reg;
        tag_wr_data[way_reg] = tag_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                meta_we      = 1'b1;
                wr_addr      = clr_idx_reg;
                meta_wr_data = meta_init;
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == SET_W'(MAX_SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (!(|hit_vec_reg) && rnd_mode)
                begin
                    lfsr_next    = lfsr_step(lfsr_reg);
                    mod_cnt_next = '0;
                    state_next   = ST_MOD;
                end
                else
                    state_next = ST_WRITE;
            end
            ST_MOD:
            begin
                mod_cnt_next = mod_cnt_reg + MCNT_W'(1);
                if (mod_cnt_reg == MCNT_W'(MOD_CYCLES - 1))
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    meta_we        = 1'b1;
                    tag_we         = !hit_reg;
                    out_valid_next = 1'b1;
                    if (acc_cnt_reg != '1)
                        acc_cnt_next = acc_cnt_reg + CNT_W'(1);
                    if (hit_reg && (hit_cnt_reg != '1))
                        hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            mod_cnt_reg   <= '0;
            lfsr_reg      <= LFSR_SEED;
            acc_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            mod_cnt_reg   <= mod_cnt_next;
            lfsr_reg      <= lfsr_next;
            acc_cnt_reg   <= acc_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LRU;
            offs_reg  <= OFFS_W'(2);
            sbits_reg <= SBITS_W'(6);
            ways_reg  <= WAYS_W'(4);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_REPLACE_MODE:      mode_reg  <= MODE_W'(cfg.data);
                CFG_BLOCK_OFFSET_BITS: offs_reg  <= OFFS_W'(cfg.data);
                CFG_SET_INDEX_BITS:    sbits_reg <= SBITS_W'(cfg.data);
                CFG_WAYS_IN_USE:       ways_reg  <= WAYS_W'(cfg.data);
                default:               mode_reg  <= mode_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            set_reg <= set_idx;
            tag_reg <= tag_val;
        end
        if (state_reg == ST_READ)
            hit_vec_reg <= hit_vec;
        if (state_reg == ST_DECIDE)
        begin
            hit_reg <= |hit_vec_reg;
            way_reg <= (|hit_vec_reg) ? hit_way : victim;
            rem_reg <= '0;
            quo_reg <= lfsr_step(lfsr_reg);
        end
        if (state_reg == ST_MOD)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            if (mod_cnt_reg == MCNT_W'(MOD_CYCLES - 1))
                way_reg <= WAY_W'(rem_step);
        end
        if ((state_reg == ST_WRITE) && out_free)
        begin
            out_hit_reg  <= hit_reg;
            out_way_reg  <= WAY_OUT_W'(way_reg);
            out_set_reg  <= SET_OUT_W'(set_reg);
            out_acc_reg  <= acc_cnt_next;
            out_hits_reg <= hit_cnt_next;
        end
    end

    // tag and metadata memories, registered read
    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            tag_rd_reg  <= tag_mem[set_idx];
            meta_rd_reg <= meta_mem[set_idx];
        end
        if (tag_we)
            tag_mem[wr_addr] <= tag_wr_data;
        if (meta_we)
            meta_mem[wr_addr] <= meta_wr_data;
    end

    // checks
    a_hits_le_accesses: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= acc_cnt_reg)
        else $error("hit count above access count");

    a_hit_way_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) && hit_reg |-> hit_vec_reg[way_reg])
        else $error("reported hit way did not match");

    a_way_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (WCNT_W'(way_reg) < ways_eff))
        else $error("way beyond associativity in use");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the cache tag lookup unit: directed and random addresses checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import sact_pkg::*;

    localparam int N_SETS = DEF_MAX_SETS;
    localparam int N_WAYS = DEF_MAX_WAYS;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic [SET_OUT_W-1:0] set_used;
        logic [CNT_W-1:0]     access_total;
        logic [CNT_W-1:0]     hit_total;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    sact_cfg_if    cfg_ch ();
    sact_lookup_if lookup_ch ();
    sact_result_if result_ch ();

    set_assoc_cache_tag_lookup_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .lookup (lookup_ch.sink),
        .result (result_ch.source)
    );

    // clock, 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of the cache state and settings
    mode_t       cur_mode;
    logic [4:0]  cur_offset;
    logic [3:0]  cur_sbits;
    logic [4:0]  cur_ways;
    logic [31:0] tag_mem   [N_SETS][N_WAYS];
    logic        valid_mem [N_SETS][N_WAYS];
    logic [4:0]  fifo_ptr  [N_SETS];
    logic [3:0]  age_order [N_SETS][N_WAYS];
    logic [15:0] lfsr;
    logic [31:0] access_cnt;
    logic [31:0] hit_cnt;

    lookup_result_t expected_results[$];
    int  fail_count;
    longint cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;

    // move a way to the most recent end of its set's age order
    function automatic void make_recent(input int s, input logic [3:0] w);
        int pos;
        pos = 0;
        for (int i = 0; i < N_WAYS; i++)
            if (age_order[s][i] == w) pos = i;
        for (int i = pos; i + 1 < N_WAYS; i++)
            age_order[s][i] = age_order[s][i + 1];
        age_order[s][N_WAYS - 1] = w;
    endfunction

    function automatic void reset_model();
        cur_mode   = MODE_LRU;
        cur_offset = 5'd2;
        cur_sbits  = 4'd6;
        cur_ways   = 5'd4;
        for (int s = 0; s < N_SETS; s++)
        begin
            fifo_ptr[s] = '0;
            for (int w = 0; w < N_WAYS; w++)
            begin
                valid_mem[s][w] = 1'b0;
                tag_mem[s][w]   = '0;
                age_order[s][w] = w[3:0];
            end
        end
        lfsr       = LFSR_SEED;
        access_cnt = '0;
        hit_cnt    = '0;
    endfunction

    // work out the result of one lookup and update the copy of the state
    function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
        lookup_result_t r;
        int sb, nw, s, way;
        logic [63:0] a64;
        logic [31:0] tg;
        logic hit;
        logic [15:0] fb;
        sb = 0;
        while (sb < cur_sbits && (2 << sb) <= N_SETS) sb++;
        nw = cur_ways;
        if (nw < 1) nw = 1;
        if (nw > N_WAYS) nw = N_WAYS;
        a64 = {32'd0, addr};
        s  = int'((a64 >> cur_offset) & ((64'd1 << sb) - 1));
        tg = 32'((a64 >> (cur_offset + sb)));
        if (access_cnt != 32'hFFFF_FFFF) access_cnt++;
        hit = 1'b0;
        way = 0;
        for (int w = 0; w < nw; w++)
            if (valid_mem[s][w] && tag_mem[s][w] == tg)
            begin
                hit = 1'b1;
                way = w;
            end
        if (hit)
        begin
            if (hit_cnt != 32'hFFFF_FFFF) hit_cnt++;
            if (cur_mode == MODE_LRU) make_recent(s, way[3:0]);
        end
        else
        begin
            if (cur_mode == MODE_FIFO)
            begin
                way = fifo_ptr[s] < nw ? int'(fifo_ptr[s]) : 0;
                fifo_ptr[s] = (way + 1 == nw) ? 5'd0 : 5'(way + 1);
            end
            else if (cur_mode == MODE_LRU)
            begin
                way = 0;
                for (int i = N_WAYS - 1; i >= 0; i--)
                    if (age_order[s][i] < nw) way = age_order[s][i];
                make_recent(s, way[3:0]);
            end
            else
            begin
                // lfsr taps 16,14,13,11, shifting right
                fb = {15'd0, lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5]};
                lfsr = {fb[0], lfsr[15:1]};
                way = int'(lfsr) % nw;
            end
            tag_mem[s][way]   = tg;
            valid_mem[s][way] = 1'b1;
        end
        r.hit          = hit;
        r.way_used     = way[3:0];
        r.set_used     = s[8:0];
        r.access_total = access_cnt;
        r.hit_total    = hit_cnt;
        return r;
    endfunction

    // send one address beat and queue its expected result; valid stays high afterwards
    // until the next idle cycle or release_lookup
    task automatic send_address(input logic [31:0] addr);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            lookup_ch.valid <= 1'b0;
            @(negedge clk);
        end
        lookup_ch.valid   <= 1'b1;
        lookup_ch.address <= addr;
        do @(posedge clk); while (!lookup_ch.ready);
        expected_results.push_back(predict_lookup(addr));
        @(negedge clk);
    endtask

    // drop the address valid after the last beat of a burst
    task automatic release_lookup();
        lookup_ch.valid <= 1'b0;
    endtask

    // register write, only while nothing is in flight
    task automatic write_reg(input cfg_idx_t idx, input logic [4:0] value);
        release_lookup();
        while (expected_results.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_REPLACE_MODE:      cur_mode   = mode_t'(value[1:0]);
            CFG_BLOCK_OFFSET_BITS: cur_offset = value;
            CFG_SET_INDEX_BITS:    cur_sbits  = value[3:0];
            default:               cur_ways   = value;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_all(input mode_t m, input logic [4:0] offs, input logic [3:0] sb,
                           input logic [4:0] ways);
        write_reg(CFG_REPLACE_MODE, {3'd0, m});
        write_reg(CFG_BLOCK_OFFSET_BITS, offs);
        write_reg(CFG_SET_INDEX_BITS, {1'b0, sb});
        write_reg(CFG_WAYS_IN_USE, ways);
    endtask

    // random address: mostly a small pool so sets fill, evict and hit
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(99) < 75)
            a = {a[31:12] & 20'h00007, a[11:0]} ^ ($urandom_range(1) ? 32'hFFFF_0000 : 32'd0);
        return a;
    endfunction

    // result sink with random stalls
    always @(negedge clk)
        result_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                lookup_result_t e;
                e = expected_results.pop_front();
                if (result_ch.hit !== e.hit)
                begin
                    $error("hit expected %0d actual %0d", e.hit, result_ch.hit);
                    fail_count++;
                end
                if (result_ch.way_used !== e.way_used)
                begin
                    $error("way_used expected %0d actual %0d", e.way_used, result_ch.way_used);
                    fail_count++;
                end
                if (result_ch.set_used !== e.set_used)
                begin
                    $error("set_used expected %0d actual %0d", e.set_used, result_ch.set_used);
                    fail_count++;
                end
                if (result_ch.access_total !== e.access_total)
                begin
                    $error("access_total expected %0d actual %0d",
                           e.access_total, result_ch.access_total);
                    fail_count++;
                end
                if (result_ch.hit_total !== e.hit_total)
                begin
                    $error("hit_total expected %0d actual %0d", e.hit_total, result_ch.hit_total);
                    fail_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // extremes of the address and the corner settings
    task automatic test_directed();
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        // too many set bits and ways above the maximum
        set_all(MODE_FIFO, 5'd0, 4'd15, 5'd31);
        send_address(32'h1234_5678);
        send_address(32'hAAAA_AAAA);
        send_address(32'h5555_5555);
        // zero ways acts as one
        set_all(MODE_RANDOM_ALT, 5'd16, 4'd0, 5'd0);
        send_address(32'h0001_0000);
        send_address(32'h0002_0000);
        send_address(32'h0002_ffff);
        // a set with the same tag in two ways: highest way reported
        set_all(MODE_FIFO, 5'd31, 4'd0, 5'd2);
        send_address(32'h0000_0000);
        write_reg(CFG_WAYS_IN_USE, 5'd1);
        send_address(32'h8000_0000);
        send_address(32'h0000_0000);
        write_reg(CFG_WAYS_IN_USE, 5'd2);
        send_address(32'h0000_0000);
        // fifo pointer beyond ways in use
        set_all(MODE_FIFO, 5'd2, 4'd1, 5'd16);
        for (int i = 0; i < 6; i++) send_address(32'(i) << 3);
        write_reg(CFG_WAYS_IN_USE, 5'd3);
        send_address(32'hF000_0000);
        send_address(32'hF100_0000);
        release_lookup();
    endtask

    task automatic test_random_phase(input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 100 == 0)
                set_all(mode_t'($urandom_range(3)), 5'($urandom_range(16)),
                        4'($urandom_range(9)), 5'($urandom_range(16, 1)));
            send_address(pick_address());
        end
        release_lookup();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_REPLACE_MODE;
        cfg_ch.data = '0;
        lookup_ch.valid = 1'b0;
        lookup_ch.address = '0;
        result_ch.ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        send_idle_pct = 7;
        recv_idle_pct = 84;
        test_random_phase(400);
        send_idle_pct = 84;
        recv_idle_pct = 7;
        test_random_phase(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(500);

        // drain, then wait out any stray result beat before the verdict
        while (expected_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/sact_pkg.sv
hw/rtl/sact_if.sv
hw/rtl/set_assoc_cache_tag_lookup_unit.sv
tb/sv/testbench.sv
